FILE: hdl/assert_macros.svh
// Assertion helpers shared by the downscaler modules.
// In synthesis builds every helper expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define RBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define RBD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define RBD_ASSERT(lbl, clk, rst, prop, msg)
`define RBD_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: hdl/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

   // Pixel and result field widths.
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 4;
   localparam int OUT_COL_W = 12;

   // Stream word widths, padded to whole bytes.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // Configuration registers.
   localparam int SRC_WIDTH_W = 13;
   localparam int SHRINK_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHRINK_LOG2  = 1'd1;

   localparam logic [SRC_WIDTH_W-1:0] SOURCE_WIDTH_RST = 13'd256;
   localparam logic [SHRINK_W-1:0]    SHRINK_LOG2_RST  = 4'd1;

   // Result queue sizing; the depth is a power of two so the pointers wrap freely.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CNT_W = 3;

   typedef logic [CHAN_W-1:0] chan_type;

   // Channel 0 is red in the lowest bits, then green, blue and alpha.
   typedef chan_type [NUM_CHAN-1:0] pixel_type;

   // Per-pixel decode handed from the scan control to the accumulate stage.
   typedef struct packed {
      logic overwrite;
      logic emit;
      logic row_done;
   } scan_flags_type;

   // One averaged output pixel as it waits in the result queue.
   typedef struct packed {
      logic                 row_done;
      logic [OUT_COL_W-1:0] out_column;
      pixel_type            pixel;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/rbd_sum_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rbd_sum_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 96
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Simple dual-port line store; a read in the same cycle as a write to the
   // same entry returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/rbd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rbd_out_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  rbd_pkg::result_type               push_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output rbd_pkg::result_type               out_data,
   output logic [rbd_pkg::FIFO_CNT_W-1:0]    count
);

   rbd_pkg::result_type                  entries_ff [rbd_pkg::FIFO_DEPTH];
   logic [rbd_pkg::FIFO_AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [rbd_pkg::FIFO_AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [rbd_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   logic                                 pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

   // Pointer and fill-level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + rbd_pkg::FIFO_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + rbd_pkg::FIFO_AW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + rbd_pkg::FIFO_CNT_W'(1);
         2'b01:   count_in = count_ff - rbd_pkg::FIFO_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RBD_ASSERT_NEVER(a_fifo_overflow, clock, reset, push && !pop && (count_ff == rbd_pkg::FIFO_CNT_W'(rbd_pkg::FIFO_DEPTH)), "result queue written while full")
   `RBD_ASSERT_NEVER(a_fifo_ptr_count, clock, reset, (rbd_pkg::FIFO_AW'(wr_ptr_ff - rd_ptr_ff) != count_ff[rbd_pkg::FIFO_AW-1:0]), "result queue pointers disagree with fill level")

endmodule

`default_nettype wire

FILE: hdl/rbd_scan_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rbd_scan_ctrl #(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_SHRINK_LOG2 = 8,
   parameter int COL_W           = 12,
   parameter int K_W             = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [rbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             accept,
   input  logic                             frame_end,
   output logic [K_W-1:0]                   eff_k,
   output logic [COL_W-1:0]                 slot,
   output rbd_pkg::scan_flags_type          flags
);

   localparam int EW_W = $clog2(MAX_WIDTH + 1);
   localparam int XW   = (COL_W > MAX_SHRINK_LOG2) ? COL_W : MAX_SHRINK_LOG2;
   localparam int DW   = ((EW_W > MAX_SHRINK_LOG2) ? EW_W : MAX_SHRINK_LOG2) + 2;

   logic [rbd_pkg::SRC_WIDTH_W-1:0] width_ff, width_in;
   logic [rbd_pkg::SHRINK_W-1:0]    shrink_ff, shrink_in;
   logic [COL_W-1:0]                col_ff, col_in;
   logic [MAX_SHRINK_LOG2-1:0]      row_ff, row_in;

   logic [EW_W-1:0]                 eff_w;
   logic [MAX_SHRINK_LOG2-1:0]      nm1;
   logic [XW-1:0]                   sub;
   logic [DW-1:0]                   col_next;
   logic                            wrap;
   logic                            last_row;
   logic                            first_sub;
   logic                            last_sub;

   // Configuration writes.
   always_comb begin
      width_in  = width_ff;
      shrink_in = shrink_ff;
      if (csr_wen) begin
         unique case (csr_index)
            rbd_pkg::CSR_SOURCE_WIDTH: width_in  = csr_wdata[rbd_pkg::SRC_WIDTH_W-1:0];
            rbd_pkg::CSR_SHRINK_LOG2:  shrink_in = csr_wdata[rbd_pkg::SHRINK_W-1:0];
         endcase
      end
   end

   // Clamp width (zero taken as one) and block size to what the line store holds.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = EW_W'(MAX_WIDTH);
      end else begin
         eff_w = EW_W'(width_ff);
      end
      if (32'(shrink_ff) > 32'(MAX_SHRINK_LOG2)) begin
         eff_k = K_W'(MAX_SHRINK_LOG2);
      end else begin
         eff_k = K_W'(shrink_ff);
      end
   end

   // Position of the current pixel within its block.
   assign nm1       = ~({MAX_SHRINK_LOG2{1'b1}} << eff_k);
   assign sub       = XW'(col_ff) & XW'(nm1);
   assign first_sub = (sub == '0);
   assign last_sub  = (sub == XW'(nm1));
   assign last_row  = (row_ff >= nm1);
   assign slot      = col_ff >> eff_k;
   assign col_next  = DW'(col_ff) + DW'(1);
   assign wrap      = (col_next >= DW'(eff_w));

   always_comb begin
      flags.overwrite = (row_ff == '0) && first_sub;
      flags.emit      = last_row && last_sub;
      flags.row_done  = (col_next + (DW'(1) << eff_k)) > DW'(eff_w);
   end

   // Raster counters; a frame end sends both back to the origin.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + MAX_SHRINK_LOG2'(1);
         end else begin
            col_in = COL_W'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rbd_pkg::SOURCE_WIDTH_RST;
         shrink_ff <= rbd_pkg::SHRINK_LOG2_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         shrink_ff <= shrink_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   `RBD_ASSERT(a_frame_end_clears, clock, reset, (accept && frame_end) |=> ((col_ff == '0) && (row_ff == '0)), "counters not cleared after frame end")
   `RBD_ASSERT(a_row_advance, clock, reset, (accept && !frame_end && wrap && !last_row) |=> (row_ff == $past(row_ff) + MAX_SHRINK_LOG2'(1)), "block row did not advance at end of source row")

endmodule

`default_nettype wire

FILE: hdl/rgba_box_downscale.sv
`timescale 1ns / 1ps
`default_nettype none

// RGBA box downscaler. Source pixels arrive in raster order, one word per
// clock while ready, and every N-by-N block (N = 2**shrink_log2) leaves as
// one pixel holding the truncated per-channel mean, with its column in the
// reduced row and a flag on the last complete block of that row. A pixel is
// taken into the pipeline: on acceptance its column slot is read from
// a line store of per-column channel sums, the next cycle adds the pixel (or
// starts a new sum on the first pixel of a block), writes the entry back and
// forms the average. A back-to-back pixel landing on the entry written in the
// cycle before is served from a forwarding register. A result enters a
// four-word queue at the clock edge after the one that takes its last pixel
// and leaves on rsp in order; req_tready falls once the queue and the
// pipeline stage together hold four words, so a stalled output does not stop
// the input until the queue backs up. The line store needs no clearing after
// reset. Configuration is meant to be written only while no pixel is in
// flight; frame_end (tlast) drops any incomplete block row.

module rgba_box_downscale #(
   parameter int MAX_WIDTH       = 4096,
   parameter int MAX_SHRINK_LOG2 = 8
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_wen,
   input  logic [rbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]   csr_wdata,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
   input  logic [rbd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // frame_end
   input  logic                             req_tlast,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // red_out [7:0], green_out [15:8], blue_out [23:16], alpha_out [31:24],
   // out_column [43:32], zero [47:44]
   output logic [rbd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // row_done
   output logic                             rsp_tlast
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int K_W     = $clog2(MAX_SHRINK_LOG2 + 1);
   localparam int SUM_W   = 2 * MAX_SHRINK_LOG2 + rbd_pkg::CHAN_W;
   localparam int LINE_W  = rbd_pkg::NUM_CHAN * SUM_W;
   localparam int BL_W    = rbd_pkg::FIFO_CNT_W + 1;

   typedef logic [rbd_pkg::NUM_CHAN-1:0][SUM_W-1:0] line_type;

   logic                            req_accept;
   logic [K_W-1:0]                  eff_k;
   logic [COL_W-1:0]                slot;
   rbd_pkg::scan_flags_type         flags;

   logic                            s1_valid_ff, s1_valid_in;
   rbd_pkg::scan_flags_type         s1_flags_ff;
   logic [COL_W-1:0]                s1_slot_ff;
   rbd_pkg::pixel_type              s1_pixel_ff;

   logic                            fwd_valid_ff, fwd_valid_in;
   logic [COL_W-1:0]                fwd_slot_ff;
   line_type                        fwd_sums_ff;

   logic [LINE_W-1:0]               rd_data;
   line_type                        base_sums;
   line_type                        new_sums;
   rbd_pkg::pixel_type              avg;
   logic [K_W:0]                    avg_shift;

   rbd_pkg::result_type             push_data;
   rbd_pkg::result_type             out_data;
   logic [rbd_pkg::FIFO_CNT_W-1:0]  fifo_count;
   logic [BL_W-1:0]                 backlog;

   // Input handshake: room must remain for the word in the pipeline stage.
   assign backlog    = BL_W'(fifo_count) + BL_W'(s1_valid_ff);
   assign req_tready = (backlog < BL_W'(rbd_pkg::FIFO_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   rbd_scan_ctrl #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_SHRINK_LOG2 (MAX_SHRINK_LOG2),
      .COL_W           (COL_W),
      .K_W             (K_W)
   ) u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .frame_end (req_tlast),
      .eff_k     (eff_k),
      .slot      (slot),
      .flags     (flags)
   );

   rbd_sum_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W),
      .DW    (LINE_W)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_slot_ff),
      .wr_data (new_sums),
      .rd_en   (req_accept),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // Accumulate stage: take the freshest copy of the entry, add the pixel
   // or start a new block sum, and form the truncated mean.
   assign avg_shift = {eff_k, 1'b0};

   always_comb begin
      if (fwd_valid_ff && (fwd_slot_ff == s1_slot_ff)) begin
         base_sums = fwd_sums_ff;
      end else begin
         base_sums = rd_data;
      end
      for (int c = 0; c < rbd_pkg::NUM_CHAN; c++) begin
         if (s1_flags_ff.overwrite) begin
            new_sums[c] = SUM_W'(s1_pixel_ff[c]);
         end else begin
            new_sums[c] = base_sums[c] + SUM_W'(s1_pixel_ff[c]);
         end
         avg[c] = rbd_pkg::CHAN_W'(new_sums[c] >> avg_shift);
      end
   end

   assign s1_valid_in  = req_accept;
   assign fwd_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   // Pipeline payload; no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flags_ff <= flags;
         s1_slot_ff  <= slot;
         s1_pixel_ff <= req_tdata;
      end
      if (s1_valid_ff) begin
         fwd_slot_ff <= s1_slot_ff;
         fwd_sums_ff <= new_sums;
      end
   end

   // Completed blocks go to the result queue.
   always_comb begin
      push_data.row_done   = s1_flags_ff.row_done;
      push_data.out_column = rbd_pkg::OUT_COL_W'(s1_slot_ff);
      push_data.pixel      = avg;
   end

   rbd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff && s1_flags_ff.emit),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = {{(rbd_pkg::RSP_DATA_W - rbd_pkg::OUT_COL_W - rbd_pkg::REQ_DATA_W){1'b0}},
                       out_data.out_column, out_data.pixel};
   assign rsp_tlast = out_data.row_done;

   `RBD_ASSERT(a_fwd_follows_write, clock, reset, fwd_valid_ff |-> $past(s1_valid_ff), "forwarding register valid without a preceding write")
   `RBD_ASSERT(a_fwd_slot_match, clock, reset, s1_valid_ff |=> (fwd_slot_ff == $past(s1_slot_ff)), "forwarding register does not hold the entry just written")

endmodule

`default_nettype wire
